### hdl/orbit_position_generator_top_assert.svh
// assertion macros shared by the checker
`ifndef ORBIT_POSITION_GENERATOR_TOP_ASSERT_SVH
`define ORBIT_POSITION_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, quiet during reset
`define OPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/opg_pkg.sv
`timescale 1ns / 1ps
package opg_pkg;

  localparam int unsigned XW = 33;   // cordic datapath width, q30 plus headroom
  localparam int unsigned ATAN_ENTRIES = 30;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE = 3'd5;

  localparam logic [14:0]        RADIUS_MIN   = 15'd256;
  localparam logic [14:0]        RADIUS_MAX   = 15'd25600;
  localparam logic [14:0]        RADIUS_RST   = 15'd2560;
  localparam logic signed [14:0] LIFT_MIN     = -15'sd12800;
  localparam logic signed [14:0] LIFT_MAX     = 15'sd12800;
  localparam logic signed [14:0] LIFT_RST     = 15'sd1280;
  localparam logic [15:0]        RATE_MIN     = 16'd41;
  localparam logic [15:0]        RATE_MAX     = 16'd40960;

  localparam logic [12:0]          DT_CAP     = 13'd6554;      // 0.1 s in q8.16
  localparam logic [25:0]          TURN_SCALE = 26'd42722830;  // 2^24 * 8 / pi
  localparam logic signed [XW-1:0] CORDIC_X0  = 33'sd652032874; // inverse gain, q30

  // atan(2^-i) in turns * 2^32
  function automatic logic [31:0] opg_atan(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // clip a 25-bit sum into the signed 24-bit position range
  function automatic logic signed [23:0] opg_sat24(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v[24] != v[23]) begin
      r = v[24] ? 24'sh800000 : 24'sh7FFFFF;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

### hdl/opg_cordic.sv
`timescale 1ns / 1ps
module opg_cordic #(
  parameter int unsigned STEPS = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [31:0]                   angle_i,
  output logic                          done_o,
  output logic signed [opg_pkg::XW-1:0] cos_o,
  output logic signed [opg_pkg::XW-1:0] sin_o
);
  import opg_pkg::*;

  localparam int unsigned N  = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;
  localparam int unsigned CW = (N > 1) ? $clog2(N) : 1;

  logic                   busy_q, done_q, neg_q;
  logic [CW-1:0]          cnt_q;
  logic signed [XW-1:0]   x_q, y_q, z_q;
  logic signed [XW-1:0]   dx, dy, atan_s;
  logic                   neg_d;
  logic [31:0]            fold;

  // angles in the left half-plane are turned by half a turn and negated after
  assign neg_d  = (angle_i - 32'h4000_0000) < 32'h8000_0000;
  assign fold   = neg_d ? (angle_i - 32'h8000_0000) : angle_i;
  assign dx     = y_q >>> cnt_q;
  assign dy     = x_q >>> cnt_q;
  assign atan_s = $signed({1'b0, opg_atan(5'(cnt_q))});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        neg_q  <= neg_d;
        cnt_q  <= '0;
        x_q    <= CORDIC_X0;
        y_q    <= '0;
        z_q    <= $signed({fold[31], fold});
      end else if (busy_q) begin
        if (!z_q[XW-1]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - atan_s;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + atan_s;
        end
        if (cnt_q == CW'(N - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          done_q <= 1'b0;
          cnt_q  <= cnt_q + 1'b1;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = neg_q ? -x_q : x_q;
  assign sin_o  = neg_q ? -y_q : y_q;

endmodule

### hdl/orbit_position_generator_top.sv
`timescale 1ns / 1ps
// Orbit position generator. Each input word is a signed q8.16 time step; a positive
// step (capped at 0.1 s) advances a 32-bit turn-fraction angle by turn_rate times the
// step, and every step returns one word with the eye position (centre plus radius
// times cos and sin, and the lift on y, all saturated q12.12), the angle and an
// advanced flag in tuser. Configuration writes must only be made while the block is
// idle; radius, lift and turn-rate writes are clamped to their legal ranges. A single
// multiplier is used for the angle increment and both radius products, and a step that
// does not advance the angle skips the increment; the sine and cosine come from one
// cordic stage that rotates once a cycle. The input is ready only between steps; the
// result sits in an output register so the next step can start while it waits to be
// taken.
module orbit_position_generator_top #(
  parameter int unsigned CORDIC_STEPS = 18
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [opg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [opg_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,   // step_time
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [103:0]                        m_axis_tdata,   // pos_x, pos_y, pos_z, phase
  output logic                                m_axis_tuser    // advanced
);
  import opg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RATE, S_TURN, S_PHASE, S_START, S_ROT, S_MULX, S_MULZ, S_OUT
  } state_e;

  state_e                 state_q;
  logic signed [23:0]     center_x_q, center_y_q, center_z_q;
  logic [14:0]            radius_q;
  logic signed [14:0]     lift_q;
  logic [15:0]            rate_q;
  logic [31:0]            phase_q;
  logic [12:0]            dt_q;
  logic                   adv_q;
  logic signed [60:0]     prod_q;
  logic signed [23:0]     px_q;
  logic                   out_valid_q;
  logic [103:0]           out_data_q;
  logic                   out_user_q;

  logic signed [33:0]     mul_a;
  logic signed [26:0]     mul_b;
  logic signed [60:0]     mul_p;
  logic signed [60:0]     prod_rnd;
  logic [55:0]            inc_rnd;
  logic signed [21:0]     off;
  logic signed [23:0]     off_sum_y;
  logic signed [23:0]     pz, py;
  logic                   in_acc;
  logic                   out_free;
  logic                   cord_start, cord_done;
  logic signed [XW-1:0]   cord_cos, cord_sin;
  logic signed [23:0]     dt_in;
  logic signed [14:0]     lift_wr;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cord_start    = (state_q == S_START);
  assign dt_in         = s_axis_tdata;
  assign lift_wr       = cfg_data_i[14:0];

  opg_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (phase_q),
    .done_o  (cord_done),
    .cos_o   (cord_cos),
    .sin_o   (cord_sin)
  );

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      S_RATE: begin
        mul_a = $signed({21'd0, dt_q});
        mul_b = $signed({11'd0, rate_q});
      end
      S_TURN: begin
        mul_a = $signed({5'd0, prod_q[28:0]});
        mul_b = $signed({1'b0, TURN_SCALE});
      end
      S_MULX: begin
        mul_a = 34'(cord_cos);
        mul_b = $signed({12'd0, radius_q});
      end
      S_MULZ: begin
        mul_a = 34'(cord_sin);
        mul_b = $signed({12'd0, radius_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign inc_rnd  = prod_q[55:0] + 56'd8388608;
  // round the radius product from q38 down to q12.12
  assign prod_rnd = prod_q + 61'sd33554432;
  assign off      = prod_rnd[47:26];
  assign off_sum_y = {{5{lift_q[14]}}, lift_q, 4'd0};
  assign pz = opg_sat24(25'(center_z_q) + 25'(off));
  assign py = opg_sat24(25'(center_y_q) + 25'(off_sum_y));

  // configuration registers; radius, lift and turn rate are clamped on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      radius_q   <= RADIUS_RST;
      lift_q     <= LIFT_RST;
      rate_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X: center_x_q <= cfg_data_i;
        CFG_CENTER_Y: center_y_q <= cfg_data_i;
        CFG_CENTER_Z: center_z_q <= cfg_data_i;
        CFG_RADIUS: begin
          if (cfg_data_i[14:0] < RADIUS_MIN)      radius_q <= RADIUS_MIN;
          else if (cfg_data_i[14:0] > RADIUS_MAX) radius_q <= RADIUS_MAX;
          else                                    radius_q <= cfg_data_i[14:0];
        end
        CFG_LIFT: begin
          if (lift_wr < LIFT_MIN)      lift_q <= LIFT_MIN;
          else if (lift_wr > LIFT_MAX) lift_q <= LIFT_MAX;
          else                         lift_q <= lift_wr;
        end
        CFG_TURN_RATE: begin
          if (cfg_data_i[15:0] < RATE_MIN)      rate_q <= RATE_MIN;
          else if (cfg_data_i[15:0] > RATE_MAX) rate_q <= RATE_MAX;
          else                                  rate_q <= cfg_data_i[15:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      dt_q        <= '0;
      adv_q       <= 1'b0;
      prod_q      <= '0;
      px_q        <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= 1'b0;
    end else begin
      // a word loaded in S_OUT takes the place of the one just taken
      if (out_valid_q && m_axis_tready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (dt_in > 24'sd0) begin
              adv_q   <= 1'b1;
              dt_q    <= (dt_in > $signed({11'd0, DT_CAP})) ? DT_CAP : dt_in[12:0];
              state_q <= S_RATE;
            end else begin
              adv_q   <= 1'b0;
              state_q <= S_START;
            end
          end
        end
        S_RATE: begin
          prod_q  <= mul_p;
          state_q <= S_TURN;
        end
        S_TURN: begin
          prod_q  <= mul_p;
          state_q <= S_PHASE;
        end
        S_PHASE: begin
          phase_q <= phase_q + inc_rnd[55:24];
          state_q <= S_START;
        end
        S_START: state_q <= S_ROT;
        S_ROT: begin
          if (cord_done) state_q <= S_MULX;
        end
        S_MULX: begin
          prod_q  <= mul_p;
          state_q <= S_MULZ;
        end
        S_MULZ: begin
          px_q    <= opg_sat24(25'(center_x_q) + 25'(off));
          prod_q  <= mul_p;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {phase_q, pz, py, px_q};
            out_user_q  <= adv_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

### hdl/opg_checker.sv
`timescale 1ns / 1ps
`include "orbit_position_generator_top_assert.svh"
module opg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [opg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [opg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [23:0]                    s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [103:0]                   m_axis_tdata,
  input logic                           m_axis_tuser
);

  // a held result stays offered and unchanged
  `OPG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `OPG_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready,
                   $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  // one step at a time: busy right after a word is taken
  `OPG_ASSERT_NEXT(a_busy_after_acc, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                   "input accepted while a step is running")
  // a new result is loaded exactly as the sequencer returns to idle
  `OPG_ASSERT_NOW(a_result_at_idle, $rose(m_axis_tvalid), s_axis_tready,
                  "result appeared while still busy")

endmodule

bind orbit_position_generator_top opg_checker u_opg_checker (.*);
